/* design/sll_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_pkg
// Types and constants shared by the static linked list engine and its checker.
// ----------------------------------------------------------------------------
package sll_pkg;

	localparam int SLOTS_DEF = 256;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	localparam logic ST_OK  = 1'b0;
	localparam logic ST_ERR = 1'b1;

	typedef struct packed {
		logic               op;
		logic [7:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic       status;
		logic [7:0] list_length;
	} rsp_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_FHEAD,
		S_WALK,
		S_LINK,
		S_VDATA,
		S_VFREE,
		S_OUT
	} state_t;

endpackage

/* design/sll_link_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_link_ram
// Link store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sll_link_ram #(
	parameter int DEPTH = sll_pkg::SLOTS_DEF,
	parameter int WIDTH = $clog2(sll_pkg::SLOTS_DEF)
) (
	input  logic                     clk,
	input  logic                     ren,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	input  logic                     wen,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ren) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/static_linked_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// static_linked_list_engine
// Cursor-based linked list in a fixed slot array with a free chain.
// ----------------------------------------------------------------------------
//  channel | direction | payload | handshake
//  req     | in        | req_t   | req_valid / req_stall
//  rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// An accepted insert or delete walks the link chain to its position, making
// one hop per cycle on the link memory; a rejected request skips the walk.
// After reset the link memory is initialised, with req_stall high.
// One request is processed at a time; a new one is taken while the previous
// response still waits in the output register for its transfer.
// ----------------------------------------------------------------------------
module static_linked_list_engine #(
	parameter int SLOTS = sll_pkg::SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_stall,
	input  sll_pkg::req_t req,
	output logic         rsp_valid,
	input  logic         rsp_stall,
	output sll_pkg::rsp_t rsp
);

	localparam int IW   = $clog2(SLOTS);
	localparam int CMPW = ((IW > 8) ? IW : 8) + 1;
	localparam logic [IW-1:0] HEAD     = IW'(SLOTS - 1);
	localparam logic [IW-1:0] FREE_END = IW'(SLOTS - 2);

	sll_pkg::state_t state_q, state_d;

	logic [IW-1:0]   init_q;
	logic [IW-1:0]   free_q;
	logic [IW-1:0]   slot_q;
	logic [IW-1:0]   cur_q;
	logic [IW-1:0]   victim_q;
	logic [7:0]      hops_q;
	logic            op_q;
	logic            err_q;
	logic [31:0]     val_q;
	logic [IW-1:0]   count_q;
	logic            rsp_valid_q;
	sll_pkg::rsp_t   rsp_q;

	logic            ren;
	logic [IW-1:0]   raddr;
	logic [IW-1:0]   rdata;
	logic            wen;
	logic [IW-1:0]   waddr;
	logic [IW-1:0]   wdata;

	logic [CMPW-1:0] pos_ext;
	logic [CMPW-1:0] cnt_ext;
	logic            req_err;
	logic            accept;
	logic            out_load;
	logic            bad_victim;

	logic [31:0]     element_mem [SLOTS];

	sll_link_ram #(
		.DEPTH(SLOTS),
		.WIDTH(IW)
	) u_link_ram (
		.clk  (clk),
		.ren  (ren),
		.raddr(raddr),
		.rdata(rdata),
		.wen  (wen),
		.waddr(waddr),
		.wdata(wdata)
	);

	assign pos_ext    = CMPW'(req.position);
	assign cnt_ext    = CMPW'(count_q);
	assign accept     = (state_q == sll_pkg::S_IDLE) && req_valid;
	assign out_load   = (state_q == sll_pkg::S_OUT) && (!rsp_valid_q || !rsp_stall);
	assign bad_victim = (rdata == '0) || (rdata == HEAD);

	always_comb begin
		if (req.op == sll_pkg::OP_INSERT) begin
			req_err = (pos_ext == '0) || (pos_ext > cnt_ext + CMPW'(1)) || (free_q == '0);
		end else begin
			req_err = (pos_ext == '0) || (pos_ext > cnt_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sll_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ren     = 1'b0;
		raddr   = HEAD;
		wen     = 1'b0;
		waddr   = cur_q;
		wdata   = slot_q;
		unique case (state_q)
			sll_pkg::S_INIT: begin
				wen   = 1'b1;
				waddr = init_q;
				wdata = (init_q < FREE_END) ? init_q + IW'(1) : '0;
				if (init_q == HEAD) begin
					state_d = sll_pkg::S_IDLE;
				end
			end
			sll_pkg::S_IDLE: begin
				if (req_valid) begin
					if (req_err) begin
						state_d = sll_pkg::S_OUT;
					end else if (req.op == sll_pkg::OP_INSERT) begin
						ren     = 1'b1;
						raddr   = free_q;
						state_d = sll_pkg::S_FHEAD;
					end else begin
						ren     = 1'b1;
						raddr   = HEAD;
						state_d = sll_pkg::S_WALK;
					end
				end
			end
			sll_pkg::S_FHEAD: begin
				ren     = 1'b1;
				raddr   = HEAD;
				state_d = sll_pkg::S_WALK;
			end
			sll_pkg::S_WALK: begin
				if (hops_q != '0) begin
					ren   = 1'b1;
					raddr = rdata;
				end else if (op_q == sll_pkg::OP_INSERT) begin
					wen     = 1'b1;
					waddr   = slot_q;
					wdata   = rdata;
					state_d = sll_pkg::S_LINK;
				end else if (bad_victim) begin
					state_d = sll_pkg::S_OUT;
				end else begin
					ren     = 1'b1;
					raddr   = rdata;
					state_d = sll_pkg::S_VDATA;
				end
			end
			sll_pkg::S_LINK: begin
				wen     = 1'b1;
				waddr   = cur_q;
				wdata   = slot_q;
				state_d = sll_pkg::S_OUT;
			end
			sll_pkg::S_VDATA: begin
				wen     = 1'b1;
				waddr   = cur_q;
				wdata   = rdata;
				state_d = sll_pkg::S_VFREE;
			end
			sll_pkg::S_VFREE: begin
				wen     = 1'b1;
				waddr   = victim_q;
				wdata   = free_q;
				state_d = sll_pkg::S_OUT;
			end
			sll_pkg::S_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = sll_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sll_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= '0;
			free_q      <= IW'(1);
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == sll_pkg::S_INIT) begin
				init_q <= init_q + IW'(1);
			end
			if (state_q == sll_pkg::S_FHEAD) begin
				free_q <= rdata;
			end
			if (state_q == sll_pkg::S_VFREE) begin
				free_q  <= victim_q;
				count_q <= count_q - IW'(1);
			end
			if (state_q == sll_pkg::S_LINK) begin
				count_q <= count_q + IW'(1);
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.op;
			slot_q <= free_q;
			val_q  <= $unsigned(req.value);
			hops_q <= req.position - 8'd1;
			cur_q  <= HEAD;
			err_q  <= req_err;
		end
		if (state_q == sll_pkg::S_WALK) begin
			if (hops_q != '0) begin
				cur_q  <= rdata;
				hops_q <= hops_q - 8'd1;
			end else if (op_q == sll_pkg::OP_DELETE) begin
				victim_q <= rdata;
				if (bad_victim) begin
					err_q <= 1'b1;
				end
			end
		end
		if (out_load) begin
			rsp_q.status      <= err_q;
			rsp_q.list_length <= cnt_ext[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sll_pkg::S_FHEAD) begin
			element_mem[slot_q] <= val_q;
		end
	end

	assign req_stall = (state_q != sll_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* design/sll_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_checker
// Port-level checks for the static linked list engine, bound to the top level.
// ----------------------------------------------------------------------------
module sll_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input sll_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input sll_pkg::rsp_t rsp
);

	logic       in_xfer;
	logic       out_xfer;
	logic [1:0] pend_q;
	logic [7:0] last_len_q;

	assign in_xfer  = req_valid && !req_stall;
	assign out_xfer = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			last_len_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
			if (out_xfer) begin
				last_len_q <= rsp.list_length;
			end
		end
	end

	a_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled response changed or was withdrawn.");

	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> pend_q != 2'd0)
		else $error("Response transfer without an outstanding request.");

	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> (rsp.list_length == last_len_q)
			|| (rsp.list_length == last_len_q + 8'd1)
			|| (rsp.list_length == last_len_q - 8'd1))
		else $error("List length moved by more than one element.");

	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && (rsp.status == sll_pkg::ST_ERR) |-> rsp.list_length == last_len_q)
		else $error("Rejected request changed the list length.");

endmodule

bind static_linked_list_engine sll_checker u_sll_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the static linked list engine.
// Requests are sent through the valid/stall channel. Each transfer is applied
// to a shadow of the link chain and the element count, which gives the
// expected status and list length. Every response transfer is then checked
// against the oldest expectation. The stimulus covers edge positions, a fill
// to a full store and a drain back to empty, and long random runs of mixed
// inserts and deletes, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;

	localparam int          NSLOT       = sll_pkg::SLOTS_DEF;
	localparam int          MAX_ELEMS   = NSLOT - 2;
	localparam int unsigned CYCLE_LIMIT = 3000000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	sll_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	sll_pkg::rsp_t rsp;

	bit          idling_on   = 1'b1;
	int unsigned stall_left  = 0;
	int unsigned cycle_count = 0;
	int unsigned fail_count  = 0;
	int unsigned n_requests  = 0;
	int unsigned n_checked   = 0;
	int unsigned n_rejected  = 0;
	int unsigned peak_length = 0;

	int unsigned   chain_link [NSLOT];
	int unsigned   list_count;
	sll_pkg::rsp_t expected_replies [$];
	sll_pkg::rsp_t oldest_reply;

	static_linked_list_engine #(.SLOTS(NSLOT)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic void clear_shadow_chain();
		for (int i = 0; i < NSLOT - 2; i++)
			chain_link[i] = i + 1;
		chain_link[NSLOT - 2] = 0;
		chain_link[NSLOT - 1] = 0;
		list_count = 0;
	endfunction

	function automatic int unsigned slot_before(int unsigned hops);
		int unsigned cur = NSLOT - 1;
		repeat (hops) cur = chain_link[cur];
		return cur;
	endfunction

	function automatic sll_pkg::rsp_t apply_list_request(sll_pkg::req_t item);
		sll_pkg::rsp_t reply;
		int unsigned   pos;
		int unsigned   free_slot;
		int unsigned   prev;
		int unsigned   victim;
		pos = item.position;
		reply.status = sll_pkg::ST_OK;
		if (item.op == sll_pkg::OP_INSERT) begin
			free_slot = chain_link[0];
			if (pos < 1 || pos > list_count + 1 || free_slot == 0) begin
				reply.status = sll_pkg::ST_ERR;
			end else begin
				chain_link[0] = chain_link[free_slot];
				prev = slot_before(pos - 1);
				chain_link[free_slot] = chain_link[prev];
				chain_link[prev] = free_slot;
				list_count++;
			end
		end else begin
			if (pos < 1 || pos > list_count) begin
				reply.status = sll_pkg::ST_ERR;
			end else begin
				prev = slot_before(pos - 1);
				victim = chain_link[prev];
				if (victim == 0 || victim == NSLOT - 1) begin
					reply.status = sll_pkg::ST_ERR;
				end else begin
					chain_link[prev] = chain_link[victim];
					chain_link[victim] = chain_link[0];
					chain_link[0] = victim;
					list_count--;
				end
			end
		end
		reply.list_length = list_count[7:0];
		return reply;
	endfunction

	// Mostly positions inside the valid range, the rest zero or past the end.
	function automatic logic [7:0] choose_position(logic op);
		int unsigned top;
		top = (op == sll_pkg::OP_INSERT) ? list_count + 1 : list_count;
		if ($urandom_range(0, 9) != 0 && top != 0)
			return 8'($urandom_range(1, top));
		if (top >= 255 || $urandom_range(0, 1) == 0)
			return 8'd0;
		return 8'($urandom_range(top + 1, 255));
	endfunction

	task automatic send_request(input logic op, input logic [7:0] pos, input logic [31:0] val);
		sll_pkg::req_t item;
		int unsigned   gap;
		item.op       = op;
		item.position = pos;
		item.value    = val;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (req_stall);
		expected_replies.push_back(apply_list_request(item));
		n_requests++;
		if (list_count > peak_length)
			peak_length = list_count;
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idling_on && $urandom_range(0, 4) == 0) begin
			rsp_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 4);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_replies.size() == 0) begin
				$error("response transfer with no request outstanding: status %0d, length %0d",
					rsp.status, rsp.list_length);
				fail_count++;
			end else begin
				oldest_reply = expected_replies.pop_front();
				n_checked++;
				if (rsp.status == sll_pkg::ST_ERR)
					n_rejected++;
				if (rsp.status !== oldest_reply.status) begin
					$error("status mismatch: expected %0d, got %0d",
						oldest_reply.status, rsp.status);
					fail_count++;
				end
				if (rsp.list_length !== oldest_reply.list_length) begin
					$error("list_length mismatch: expected %0d, got %0d",
						oldest_reply.list_length, rsp.list_length);
					fail_count++;
				end
			end
		end
	end

	task automatic test_edge_positions();
		send_request(sll_pkg::OP_DELETE, 8'd1, $urandom);
		send_request(sll_pkg::OP_INSERT, 8'd0, $urandom);
		send_request(sll_pkg::OP_INSERT, 8'd2, $urandom);
		send_request(sll_pkg::OP_INSERT, 8'd1, 32'h7FFF_FFFF);
		send_request(sll_pkg::OP_INSERT, 8'd1, 32'h8000_0000);
		send_request(sll_pkg::OP_INSERT, 8'd3, 32'h0000_0000);
		send_request(sll_pkg::OP_INSERT, 8'd2, 32'hFFFF_FFFF);
		send_request(sll_pkg::OP_INSERT, 8'd255, $urandom);
		send_request(sll_pkg::OP_INSERT, 8'd6, $urandom);
		send_request(sll_pkg::OP_DELETE, 8'd0, $urandom);
		send_request(sll_pkg::OP_DELETE, 8'd5, $urandom);
		send_request(sll_pkg::OP_DELETE, 8'd255, $urandom);
		send_request(sll_pkg::OP_DELETE, 8'd4, $urandom);
		send_request(sll_pkg::OP_DELETE, 8'd2, $urandom);
		send_request(sll_pkg::OP_DELETE, 8'd1, $urandom);
		send_request(sll_pkg::OP_DELETE, 8'd1, $urandom);
		send_request(sll_pkg::OP_DELETE, 8'd1, $urandom);
		send_request(sll_pkg::OP_INSERT, 8'd1, $urandom);
	endtask

	task automatic test_full_store();
		while (list_count < MAX_ELEMS)
			send_request(sll_pkg::OP_INSERT, 8'($urandom_range(1, list_count + 1)), $urandom);
		send_request(sll_pkg::OP_INSERT, 8'd255, $urandom);
		send_request(sll_pkg::OP_INSERT, 8'd1, $urandom);
		send_request(sll_pkg::OP_INSERT, 8'd0, $urandom);
		send_request(sll_pkg::OP_DELETE, 8'd255, $urandom);
		send_request(sll_pkg::OP_DELETE, 8'(MAX_ELEMS), $urandom);
		send_request(sll_pkg::OP_INSERT, 8'(MAX_ELEMS), $urandom);
		while (list_count > 0)
			send_request(sll_pkg::OP_DELETE, 8'($urandom_range(1, list_count)), $urandom);
	endtask

	task automatic test_random_mix(input int unsigned items, input int unsigned grow_pct);
		logic op;
		for (int unsigned n = 0; n < items; n++) begin
			if (n % 50 == 0)
				idling_on = ($urandom_range(0, 3) != 0);
			op = ($urandom_range(0, 99) < grow_pct) ? sll_pkg::OP_INSERT : sll_pkg::OP_DELETE;
			send_request(op, choose_position(op), $urandom);
		end
	endtask

	task automatic test_back_to_back(input int unsigned items);
		logic op;
		idling_on = 1'b0;
		for (int unsigned n = 0; n < items; n++) begin
			op = ($urandom_range(0, 1) == 0) ? sll_pkg::OP_INSERT : sll_pkg::OP_DELETE;
			send_request(op, choose_position(op), $urandom);
		end
	endtask

	initial begin
		clear_shadow_chain();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_edge_positions();
		test_full_store();
		test_random_mix(300, 70);
		test_random_mix(300, 30);
		test_random_mix(100, 85);
		test_random_mix(300, 15);
		test_random_mix(200, 50);
		test_back_to_back(300);

		@(posedge clk);
		req_valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d requests, %0d responses checked, %0d of them rejected.",
			n_requests, n_checked, n_rejected);
		$display("Longest list reached %0d elements; %0d mismatches found.",
			peak_length, fail_count);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* sim.f */
design/sll_pkg.sv
design/sll_link_ram.sv
design/static_linked_list_engine.sv
design/sll_checker.sv
tb/testbench.sv
